@@ design/cds_pkg.sv @@
// Shared constants and status codes for the Smith complex divider.
`default_nettype none
package cds_pkg;

  // Fraction bits kept in the pivot ratio
  localparam int RATIO_BITS = 30;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

endpackage
`default_nettype wire

@@ design/cds_cell.sv @@
// One restoring-division cell: one quotient bit per cell, registered to the next cell.
`default_nettype none
module cds_cell #(
  parameter int DW = 32,
  parameter int LW = 1,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          prev_valid,
  input  wire logic [DW-1:0] prev_rem,
  input  wire logic [DW-1:0] prev_div,
  input  wire logic [LW-1:0] prev_low,
  input  wire logic [QW-1:0] prev_quo,
  input  wire logic [SW-1:0] prev_side,
  output logic               valid,
  output logic [DW-1:0]      rem,
  output logic [DW-1:0]      div,
  output logic [LW-1:0]      low,
  output logic [QW-1:0]      quo,
  output logic [SW-1:0]      side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_next;

  // Remainder stays below the divisor, so the trial fits in DW+1 bits
  always_comb begin
    trial    = {prev_rem, prev_low[LW-1]};
    diff     = trial - {1'b0, prev_div};
    fits     = (trial >= {1'b0, prev_div});
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      div  <= prev_div;
      low  <= prev_low << 1;
      quo  <= {prev_quo[QW-2:0], fits};
      side <= prev_side;
    end
  end

endmodule
`default_nettype wire

@@ design/complex_divide_smith.sv @@
// Top level of the Smith complex divider pipeline.
// Divides (num_re + j num_im) by (den_re + j den_im), all signed fixed point with
// FRAC_BITS fraction bits, by Smith's method. The larger-magnitude denominator part
// is the pivot (real wins a tie); the other part over the pivot gives a ratio of
// at most one, held with 30 fraction bits and truncated toward zero. The scaled
// denominator and both dividends are formed exactly, then each quotient part is
// truncated toward zero and saturated. status: ST_OK, ST_SAT when either part
// saturated, ST_DIV_ZERO (zero quotient) for a zero denominator. One transaction
// is taken per cycle while in_stall is low. From acceptance to the output register
// a transaction passes S0, S1, a chain of 30 restoring-division cells for the ratio,
// S2 to S5, WORD_BITS + 1 cells (two lanes, real and imaginary) for the quotients, S6.
// An output register plus one skid entry part the two sides: in_stall rises only
// when a result is held in the skid entry, and the whole pipeline then freezes.
`default_nettype none
module complex_divide_smith #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [WORD_BITS-1:0] num_re,
  input  wire logic signed [WORD_BITS-1:0] num_im,
  input  wire logic signed [WORD_BITS-1:0] den_re,
  input  wire logic signed [WORD_BITS-1:0] den_im,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [WORD_BITS-1:0]      quo_re,
  output logic signed [WORD_BITS-1:0]      quo_im,
  output cds_pkg::status_t                 status
);
  import cds_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int RB  = RATIO_BITS;
  localparam int RW  = RB + 1;          // ratio width, value up to 2^RB
  localparam int MW  = W + RB + 1;      // product / dividend / denominator magnitude
  localparam int SW  = MW + 1;          // signed sums
  localparam int NB  = MW + FRAC_BITS;  // shifted dividend
  localparam int QB  = W + 1;           // quotient bits resolved by the cells
  localparam int RSW = 3 * W + 6;       // side data through the ratio chain
  localparam logic [QB-1:0] HALF = {2'b00, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

  // Pipeline advances unless the skid entry is occupied
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // ---------------- S0: magnitudes and signs ----------------
  logic         s0_valid;
  logic [W-1:0] s0_nr, s0_ni, s0_dr, s0_di;
  logic         s0_nrn, s0_nin, s0_drn, s0_din;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_nr  <= mag_of(num_re);
      s0_ni  <= mag_of(num_im);
      s0_dr  <= mag_of(den_re);
      s0_di  <= mag_of(den_im);
      s0_nrn <= num_re[W-1];
      s0_nin <= num_im[W-1];
      s0_drn <= den_re[W-1];
      s0_din <= den_im[W-1];
    end
  end

  // ---------------- S1: pivot choice, first ratio bit ----------------
  logic         s1_valid;
  logic [W-1:0] s1_pm, s1_rem;
  logic [RW-1:0] s1_quo;
  logic [RSW-1:0] s1_side;
  logic         real_pivot;
  logic [W-1:0] piv, oth;
  logic         piv_neg, oth_neg, tie;

  always_comb begin
    real_pivot = (s0_dr >= s0_di);
    piv        = real_pivot ? s0_dr : s0_di;
    oth        = real_pivot ? s0_di : s0_dr;
    piv_neg    = real_pivot ? s0_drn : s0_din;
    oth_neg    = real_pivot ? s0_din : s0_drn;
    tie        = (s0_dr == s0_di);     // ratio is exactly one
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pm   <= piv;
      s1_rem  <= tie ? '0 : oth;
      s1_quo  <= {{(RW-1){1'b0}}, tie};
      s1_side <= {oth, s0_nr, s0_ni, s0_nrn, s0_nin, piv_neg, oth_neg, real_pivot,
                  (s0_dr == '0) && (s0_di == '0)};
    end
  end

  // ---------------- ratio chain ----------------
  logic          rc_valid [0:RB];
  logic [W-1:0]  rc_rem   [0:RB];
  logic [W-1:0]  rc_div   [0:RB];
  logic          rc_low   [0:RB];
  logic [RW-1:0] rc_quo   [0:RB];
  logic [RSW-1:0] rc_side [0:RB];

  assign rc_valid[0] = s1_valid;
  assign rc_rem[0]   = s1_rem;
  assign rc_div[0]   = s1_pm;
  assign rc_low[0]   = 1'b0;
  assign rc_quo[0]   = s1_quo;
  assign rc_side[0]  = s1_side;

  for (genvar gi = 0; gi < RB; gi++) begin : g_ratio
    cds_cell #(.DW(W), .LW(1), .QW(RW), .SW(RSW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (rc_valid[gi]),
      .prev_rem   (rc_rem[gi]),
      .prev_div   (rc_div[gi]),
      .prev_low   (rc_low[gi]),
      .prev_quo   (rc_quo[gi]),
      .prev_side  (rc_side[gi]),
      .valid      (rc_valid[gi+1]),
      .rem        (rc_rem[gi+1]),
      .div        (rc_div[gi+1]),
      .low        (rc_low[gi+1]),
      .quo        (rc_quo[gi+1]),
      .side       (rc_side[gi+1])
    );
  end

  // ---------------- S2: ratio products ----------------
  logic [W-1:0] r_sm, r_nr, r_ni;
  logic         r_nrn, r_nin, r_pn, r_sn, r_real, r_zero;
  assign {r_sm, r_nr, r_ni, r_nrn, r_nin, r_pn, r_sn, r_real, r_zero} = rc_side[RB];

  logic          s2_valid;
  logic [MW-1:0] s2_rs, s2_rnr, s2_rni;
  logic [W-1:0]  s2_pm, s2_nr, s2_ni;
  logic          s2_nrn, s2_nin, s2_pn, s2_sn, s2_real, s2_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= rc_valid[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rs   <= {{W{1'b0}}, rc_quo[RB]} * {{RW{1'b0}}, r_sm};
      s2_rnr  <= {{W{1'b0}}, rc_quo[RB]} * {{RW{1'b0}}, r_nr};
      s2_rni  <= {{W{1'b0}}, rc_quo[RB]} * {{RW{1'b0}}, r_ni};
      s2_pm   <= rc_div[RB];
      s2_nr   <= r_nr;
      s2_ni   <= r_ni;
      s2_nrn  <= r_nrn;
      s2_nin  <= r_nin;
      s2_pn   <= r_pn;
      s2_sn   <= r_sn;
      s2_real <= r_real;
      s2_zero <= r_zero;
    end
  end

  // ---------------- S3: scaled denominator and signed dividends ----------------
  function automatic logic signed [SW-1:0] sterm(input logic [MW-1:0] m, input logic neg);
    logic signed [SW-1:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  logic [MW-1:0] a_nr, a_ni, a_pm;
  logic          rn;
  logic signed [SW-1:0] sre_next, sim_next;

  always_comb begin
    a_nr = {1'b0, s2_nr, {RB{1'b0}}};
    a_ni = {1'b0, s2_ni, {RB{1'b0}}};
    a_pm = {1'b0, s2_pm, {RB{1'b0}}};
    rn   = s2_sn ^ s2_pn;
    if (s2_real) begin
      sre_next = sterm(a_nr, s2_nrn) + sterm(s2_rni, rn ^ s2_nin);
      sim_next = sterm(a_ni, s2_nin) + sterm(s2_rnr, !(rn ^ s2_nrn));
    end else begin
      sre_next = sterm(s2_rnr, rn ^ s2_nrn) + sterm(a_ni, s2_nin);
      sim_next = sterm(s2_rni, rn ^ s2_nin) + sterm(a_nr, !s2_nrn);
    end
  end

  logic                 s3_valid;
  logic signed [SW-1:0] s3_sre, s3_sim;
  logic [MW-1:0]        s3_den;
  logic                 s3_pn, s3_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  // The ratio term always carries the pivot's sign, so the denominator only adds
  always_ff @(posedge clk) begin
    if (en) begin
      s3_sre  <= sre_next;
      s3_sim  <= sim_next;
      s3_den  <= a_pm + s2_rs;
      s3_pn   <= s2_pn;
      s3_zero <= s2_zero;
    end
  end

  // ---------------- S4: dividend magnitudes, quotient signs ----------------
  logic signed [SW-1:0] abs_re, abs_im;
  always_comb begin
    abs_re = s3_sre[SW-1] ? -s3_sre : s3_sre;
    abs_im = s3_sim[SW-1] ? -s3_sim : s3_sim;
  end

  logic          s4_valid;
  logic [MW-1:0] s4_mre, s4_mim, s4_den;
  logic          s4_nre, s4_nim, s4_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mre  <= abs_re[MW-1:0];
      s4_mim  <= abs_im[MW-1:0];
      s4_den  <= s3_den;
      s4_nre  <= s3_sre[SW-1] ^ s3_pn;
      s4_nim  <= s3_sim[SW-1] ^ s3_pn;
      s4_zero <= s3_zero;
    end
  end

  // ---------------- S5: overflow test and quotient chain start ----------------
  logic [NB-1:0] n_re, n_im, hi_re, hi_im, den_ext;
  always_comb begin
    n_re    = {s4_mre, {FRAC_BITS{1'b0}}};
    n_im    = {s4_mim, {FRAC_BITS{1'b0}}};
    hi_re   = n_re >> QB;
    hi_im   = n_im >> QB;
    den_ext = {{FRAC_BITS{1'b0}}, s4_den};
  end

  logic          s5_valid;
  logic [MW-1:0] s5_rre, s5_rim, s5_den;
  logic [QB-1:0] s5_lre, s5_lim;
  logic [2:0]    s5_side_re;
  logic [1:0]    s5_side_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  // Side data: sign, overflow (and the zero-denominator flag on the real lane)
  always_ff @(posedge clk) begin
    if (en) begin
      s5_rre     <= hi_re[MW-1:0];
      s5_rim     <= hi_im[MW-1:0];
      s5_lre     <= n_re[QB-1:0];
      s5_lim     <= n_im[QB-1:0];
      s5_den     <= s4_den;
      s5_side_re <= {s4_nre, (hi_re >= den_ext), s4_zero};
      s5_side_im <= {s4_nim, (hi_im >= den_ext)};
    end
  end

  // ---------------- quotient chains, real and imaginary lanes ----------------
  logic          qr_valid [0:QB];
  logic [MW-1:0] qr_rem   [0:QB];
  logic [MW-1:0] qr_div   [0:QB];
  logic [QB-1:0] qr_low   [0:QB];
  logic [QB-1:0] qr_quo   [0:QB];
  logic [2:0]    qr_side  [0:QB];
  logic          qi_valid [0:QB];
  logic [MW-1:0] qi_rem   [0:QB];
  logic [MW-1:0] qi_div   [0:QB];
  logic [QB-1:0] qi_low   [0:QB];
  logic [QB-1:0] qi_quo   [0:QB];
  logic [1:0]    qi_side  [0:QB];

  assign qr_valid[0] = s5_valid;
  assign qr_rem[0]   = s5_rre;
  assign qr_div[0]   = s5_den;
  assign qr_low[0]   = s5_lre;
  assign qr_quo[0]   = '0;
  assign qr_side[0]  = s5_side_re;
  assign qi_valid[0] = s5_valid;
  assign qi_rem[0]   = s5_rim;
  assign qi_div[0]   = s5_den;
  assign qi_low[0]   = s5_lim;
  assign qi_quo[0]   = '0;
  assign qi_side[0]  = s5_side_im;

  for (genvar gq = 0; gq < QB; gq++) begin : g_quo
    cds_cell #(.DW(MW), .LW(QB), .QW(QB), .SW(3)) u_re (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (qr_valid[gq]),
      .prev_rem   (qr_rem[gq]),
      .prev_div   (qr_div[gq]),
      .prev_low   (qr_low[gq]),
      .prev_quo   (qr_quo[gq]),
      .prev_side  (qr_side[gq]),
      .valid      (qr_valid[gq+1]),
      .rem        (qr_rem[gq+1]),
      .div        (qr_div[gq+1]),
      .low        (qr_low[gq+1]),
      .quo        (qr_quo[gq+1]),
      .side       (qr_side[gq+1])
    );
    cds_cell #(.DW(MW), .LW(QB), .QW(QB), .SW(2)) u_im (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (qi_valid[gq]),
      .prev_rem   (qi_rem[gq]),
      .prev_div   (qi_div[gq]),
      .prev_low   (qi_low[gq]),
      .prev_quo   (qi_quo[gq]),
      .prev_side  (qi_side[gq]),
      .valid      (qi_valid[gq+1]),
      .rem        (qi_rem[gq+1]),
      .div        (qi_div[gq+1]),
      .low        (qi_low[gq+1]),
      .quo        (qi_quo[gq+1]),
      .side       (qi_side[gq+1])
    );
  end

  // ---------------- S6: saturation ----------------
  logic          f_nre, f_ovre, f_zero, f_nim, f_ovim;
  logic [QB-1:0] lim_re, lim_im;
  logic          sat_re, sat_im;
  always_comb begin
    {f_nre, f_ovre, f_zero} = qr_side[QB];
    {f_nim, f_ovim}         = qi_side[QB];
    lim_re = f_nre ? HALF + 1'b1 : HALF;
    lim_im = f_nim ? HALF + 1'b1 : HALF;
    sat_re = f_ovre || (qr_quo[QB] > lim_re);
    sat_im = f_ovim || (qi_quo[QB] > lim_im);
  end

  logic          s6_valid;
  logic [QB-1:0] s6_mre, s6_mim;
  logic          s6_nre, s6_nim, s6_sat, s6_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= qr_valid[QB] && qi_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_mre  <= sat_re ? lim_re : qr_quo[QB];
      s6_mim  <= sat_im ? lim_im : qi_quo[QB];
      s6_nre  <= f_nre;
      s6_nim  <= f_nim;
      s6_sat  <= sat_re || sat_im;
      s6_zero <= f_zero;
    end
  end

  // ---------------- result formatting ----------------
  logic [QB-1:0]  v_re, v_im;
  logic [W-1:0]   fin_re, fin_im;
  status_t        fin_st;
  always_comb begin
    v_re = s6_nre ? -s6_mre : s6_mre;
    v_im = s6_nim ? -s6_mim : s6_mim;
    if (s6_zero) begin
      fin_re = '0;
      fin_im = '0;
      fin_st = ST_DIV_ZERO;
    end else begin
      fin_re = v_re[W-1:0];
      fin_im = v_im[W-1:0];
      fin_st = s6_sat ? ST_SAT : ST_OK;
    end
  end

  // ---------------- output register with skid entry ----------------
  logic         out_take;
  logic [W-1:0] skid_re, skid_im;
  status_t      skid_st;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (s6_valid) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        quo_re <= skid_re;
        quo_im <= skid_im;
        status <= skid_st;
      end
    end else if (s6_valid) begin
      if (out_valid && !out_take) begin
        skid_re <= fin_re;
        skid_im <= fin_im;
        skid_st <= fin_st;
      end else begin
        quo_re <= fin_re;
        quo_im <= fin_im;
        status <= fin_st;
      end
    end
  end

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a transaction while the output register is empty");

  a_zero_quotient: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DIV_ZERO) |-> (quo_re == '0 && quo_im == '0))
    else $error("zero denominator gave a nonzero quotient");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SAT) |->
      (quo_re == MAXV || quo_re == MINV || quo_im == MAXV || quo_im == MINV))
    else $error("saturation reported without an extreme quotient");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    qr_valid[QB] == qi_valid[QB])
    else $error("real and imaginary quotient lanes out of step");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("transaction present right after reset");

endmodule
`default_nettype wire
